[rtl/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants of the first-fit heap allocator
// Holds the request and response words, the function and status codes, the
// controller states and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int HEAP_BYTES_DEFAULT = 4096;
   localparam int HDR_BYTES          = 8;
   // A rounded request is at most 8191 + 7 bytes, that is 1024 slots.
   localparam int WANT_W             = 11;

   localparam logic [1:0] FUNC_ALLOC = 2'd0;
   localparam logic [1:0] FUNC_FREE  = 2'd1;
   localparam logic [1:0] FUNC_LEAK  = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_ZERO    = 2'd1;
   localparam logic [1:0] STATUS_NOMEM   = 2'd2;
   localparam logic [1:0] STATUS_BAD_PTR = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [12:0] req_size;
      logic        ptr_is_null;
      logic [12:0] free_offset;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] payload_offset;
      logic [8:0]  leaked_objects;
      logic [11:0] leaked_bytes;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DISPATCH,
      ST_READ,
      ST_EVAL,
      ST_WR_HEAD,
      ST_MREAD,
      ST_MEVAL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       init_wr;
      logic       load;
      logic       rd_pos;
      logic       rd_nx;
      logic       advance;
      logic       count;
      logic       wr_split;
      logic       wr_alloc_want;
      logic       wr_alloc_whole;
      logic       wr_free_start;
      logic       wr_merge;
      logic       status_en;
      logic [1:0] status_code;
   } cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       req_zero;
      logic       free_bad;
      logic       fits;
      logic       split_ok;
      logic       hdr_alloc;
      logic       off_match;
      logic       walk_end;
      logic       merge_end;
   } sts_type;

endpackage

[rtl/ffha_dpath.sv]
// ----------------------------------------------------------------------------
// ffha_dpath: header memory and walk datapath
// Holds the header store, the walk pointer, the merge registers and the
// result registers, and reports compare results to the controller.
// ----------------------------------------------------------------------------
module ffha_dpath #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic             clock,
   input  ffha_pkg::req_type req_in,
   input  ffha_pkg::cmd_type cmd,
   output ffha_pkg::sts_type sts,
   output ffha_pkg::rsp_type rsp_out
);

   localparam int SLOT_COUNT = HEAP_BYTES / ffha_pkg::HDR_BYTES;
   localparam int SLOT_W     = $clog2(SLOT_COUNT);
   localparam int POS_W      = $clog2(SLOT_COUNT + 1);
   localparam int ENTRY_W    = SLOT_W + 1;
   localparam int CMP_W      = ((POS_W > ffha_pkg::WANT_W) ? POS_W : ffha_pkg::WANT_W) + 2;

   // A header holds the payload size in 8-byte slots and the allocated bit.
   logic [ENTRY_W-1:0] mem [SLOT_COUNT];

   ffha_pkg::req_type           req_ff;
   logic [ffha_pkg::WANT_W-1:0] want_ff;
   logic [POS_W-1:0]            pos_ff;
   logic [POS_W-1:0]            nx_ff;
   logic [SLOT_W-1:0]           acc_ff;
   logic [POS_W-1:0]            objs_ff;
   logic [POS_W-1:0]            slots_ff;
   logic [1:0]                  status_ff;
   logic [11:0]                 payload_ff;
   logic [ENTRY_W-1:0]          rd_data_ff;

   logic [SLOT_W-1:0]  hsize;
   logic               halloc;
   logic [CMP_W-1:0]   hsize_c;
   logic [CMP_W-1:0]   want_c;
   logic [CMP_W-1:0]   pos_c;
   logic [CMP_W-1:0]   next_c;
   logic [CMP_W-1:0]   merge_acc_c;
   logic [CMP_W-1:0]   slot_count_c;
   logic [ffha_pkg::WANT_W-1:0] want_in;

   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;
   logic               rd_en;
   logic [SLOT_W-1:0]  rd_addr;

   assign hsize        = rd_data_ff[ENTRY_W-1:1];
   assign halloc       = rd_data_ff[0];
   assign hsize_c      = CMP_W'(hsize);
   assign want_c       = CMP_W'(want_ff);
   assign pos_c        = CMP_W'(pos_ff);
   assign next_c       = pos_c + CMP_W'(1) + hsize_c;
   assign merge_acc_c  = CMP_W'(acc_ff) + CMP_W'(1) + hsize_c;
   assign slot_count_c = CMP_W'(SLOT_COUNT);

   // Round the request up to whole slots.
   assign want_in = ffha_pkg::WANT_W'((14'(req_in.req_size) + 14'd7) >> 3);

   always_comb begin
      sts.func      = req_ff.func;
      sts.req_zero  = (req_ff.req_size == 13'd0);
      sts.free_bad  = req_ff.ptr_is_null || (req_ff.free_offset < 13'd8) ||
                      (32'(req_ff.free_offset) >= 32'(HEAP_BYTES));
      sts.fits      = !halloc && (hsize_c >= want_c);
      sts.split_ok  = (hsize_c >= want_c + CMP_W'(2));
      sts.hdr_alloc = halloc;
      sts.off_match = (req_ff.free_offset[2:0] == 3'b000) &&
                      (CMP_W'(req_ff.free_offset[12:3]) == pos_c + CMP_W'(1));
      sts.walk_end  = (next_c >= slot_count_c);
      sts.merge_end = (CMP_W'(nx_ff) >= slot_count_c);
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = SLOT_W'(pos_ff);
      wr_data = '0;
      if (cmd.init_wr) begin
         wr_en   = 1'b1;
         wr_addr = '0;
         wr_data = {SLOT_W'(SLOT_COUNT - 1), 1'b0};
      end else if (cmd.wr_split) begin
         wr_en   = 1'b1;
         wr_addr = SLOT_W'(pos_c + CMP_W'(1) + want_c);
         wr_data = {SLOT_W'(hsize_c - want_c - CMP_W'(1)), 1'b0};
      end else if (cmd.wr_alloc_want) begin
         wr_en   = 1'b1;
         wr_data = {SLOT_W'(want_ff), 1'b1};
      end else if (cmd.wr_alloc_whole) begin
         wr_en   = 1'b1;
         wr_data = {hsize, 1'b1};
      end else if (cmd.wr_free_start) begin
         wr_en   = 1'b1;
         wr_data = {hsize, 1'b0};
      end else if (cmd.wr_merge) begin
         wr_en   = 1'b1;
         wr_data = {SLOT_W'(merge_acc_c), 1'b0};
      end
   end

   assign rd_en   = cmd.rd_pos || cmd.rd_nx;
   assign rd_addr = cmd.rd_pos ? SLOT_W'(pos_ff) : SLOT_W'(nx_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff     <= req_in;
         want_ff    <= want_in;
         pos_ff     <= '0;
         objs_ff    <= '0;
         slots_ff   <= '0;
         payload_ff <= '0;
         status_ff  <= ffha_pkg::STATUS_OK;
      end else begin
         if (cmd.advance) begin
            pos_ff <= POS_W'(next_c);
         end
         if (cmd.count && halloc) begin
            objs_ff  <= objs_ff + POS_W'(1);
            slots_ff <= slots_ff + POS_W'(hsize);
         end
         if (cmd.wr_alloc_want || cmd.wr_alloc_whole) begin
            payload_ff <= 12'((pos_c + CMP_W'(1)) << 3);
         end
         if (cmd.wr_free_start) begin
            acc_ff <= hsize;
            nx_ff  <= POS_W'(next_c);
         end
         if (cmd.wr_merge) begin
            acc_ff <= SLOT_W'(merge_acc_c);
            nx_ff  <= POS_W'(pos_c + CMP_W'(1) + merge_acc_c);
         end
         if (cmd.status_en) begin
            status_ff <= cmd.status_code;
         end
      end
   end

   always_comb begin
      rsp_out.status         = status_ff;
      rsp_out.payload_offset = payload_ff;
      rsp_out.leaked_objects = 9'(objs_ff);
      rsp_out.leaked_bytes   = 12'(32'(slots_ff) << 3);
   end

endmodule

[rtl/ffha_ctrl.sv]
// ----------------------------------------------------------------------------
// ffha_ctrl: sequencing state machine of the allocator
// Steps the datapath through header reads, compares and header writes for
// each request, and raises the response strobe.
// ----------------------------------------------------------------------------
module ffha_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ffha_pkg::sts_type sts,
   output ffha_pkg::cmd_type cmd,
   output logic              busy,
   output logic              rsp_valid
);

   ffha_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = (state_ff != ffha_pkg::ST_IDLE);
      rsp_valid = (state_ff == ffha_pkg::ST_RESP);
      unique case (state_ff)
         ffha_pkg::ST_INIT: begin
            cmd.init_wr = 1'b1;
            state_in    = ffha_pkg::ST_IDLE;
         end
         ffha_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ffha_pkg::ST_DISPATCH;
            end
         end
         ffha_pkg::ST_DISPATCH: begin
            unique case (sts.func)
               ffha_pkg::FUNC_ALLOC: begin
                  if (sts.req_zero) begin
                     cmd.status_en   = 1'b1;
                     cmd.status_code = ffha_pkg::STATUS_ZERO;
                     state_in        = ffha_pkg::ST_RESP;
                  end else begin
                     state_in = ffha_pkg::ST_READ;
                  end
               end
               ffha_pkg::FUNC_FREE: begin
                  if (sts.free_bad) begin
                     cmd.status_en   = 1'b1;
                     cmd.status_code = ffha_pkg::STATUS_BAD_PTR;
                     state_in        = ffha_pkg::ST_RESP;
                  end else begin
                     state_in = ffha_pkg::ST_READ;
                  end
               end
               ffha_pkg::FUNC_LEAK: begin
                  state_in = ffha_pkg::ST_READ;
               end
               default: begin
                  state_in = ffha_pkg::ST_RESP;
               end
            endcase
         end
         ffha_pkg::ST_READ: begin
            cmd.rd_pos = 1'b1;
            state_in   = ffha_pkg::ST_EVAL;
         end
         ffha_pkg::ST_EVAL: begin
            unique case (sts.func)
               ffha_pkg::FUNC_ALLOC: begin
                  if (sts.fits) begin
                     if (sts.split_ok) begin
                        cmd.wr_split = 1'b1;
                        state_in     = ffha_pkg::ST_WR_HEAD;
                     end else begin
                        cmd.wr_alloc_whole = 1'b1;
                        state_in           = ffha_pkg::ST_RESP;
                     end
                  end else if (sts.walk_end) begin
                     cmd.status_en   = 1'b1;
                     cmd.status_code = ffha_pkg::STATUS_NOMEM;
                     state_in        = ffha_pkg::ST_RESP;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = ffha_pkg::ST_READ;
                  end
               end
               ffha_pkg::FUNC_FREE: begin
                  if (sts.off_match && sts.hdr_alloc) begin
                     cmd.wr_free_start = 1'b1;
                     state_in          = ffha_pkg::ST_MREAD;
                  end else if (sts.off_match || sts.walk_end) begin
                     cmd.status_en   = 1'b1;
                     cmd.status_code = ffha_pkg::STATUS_BAD_PTR;
                     state_in        = ffha_pkg::ST_RESP;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = ffha_pkg::ST_READ;
                  end
               end
               default: begin
                  cmd.count = 1'b1;
                  if (sts.walk_end) begin
                     state_in = ffha_pkg::ST_RESP;
                  end else begin
                     cmd.advance = 1'b1;
                     state_in    = ffha_pkg::ST_READ;
                  end
               end
            endcase
         end
         ffha_pkg::ST_WR_HEAD: begin
            cmd.wr_alloc_want = 1'b1;
            state_in          = ffha_pkg::ST_RESP;
         end
         ffha_pkg::ST_MREAD: begin
            if (sts.merge_end) begin
               state_in = ffha_pkg::ST_RESP;
            end else begin
               cmd.rd_nx = 1'b1;
               state_in  = ffha_pkg::ST_MEVAL;
            end
         end
         ffha_pkg::ST_MEVAL: begin
            if (sts.hdr_alloc) begin
               state_in = ffha_pkg::ST_RESP;
            end else begin
               cmd.wr_merge = 1'b1;
               state_in     = ffha_pkg::ST_MREAD;
            end
         end
         ffha_pkg::ST_RESP: begin
            state_in = ffha_pkg::ST_IDLE;
         end
         default: begin
            state_in = ffha_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator: first-fit allocator over an implicit header list
// Manages a heap as a chain of 8-byte headers held in an on-chip header
// store, serving allocate, free and leak report requests one at a time.
//
// Usage: drive a request word on req_item and raise start. The word is taken
// at the rising edge where start is high and busy is low; busy then stays
// high until the response has been shown. Each request gives exactly one
// response word on rsp_item, marked by a one-cycle rsp_valid strobe, and
// busy drops in the cycle after the strobe. The receiver cannot stall the
// block, so it must capture the word while rsp_valid is high.
// Sequence: a request that needs no walk (zero size, rejected pointer, unused
// function code) goes from the accepting cycle through dispatch straight to
// the response. A walk reads and compares the headers one at a time, since
// every header is a registered read of the header store. A split adds a
// second header write. After a free has released its block it checks the
// following headers one at a time, merging each free one, and stops on an
// allocated block or when it reaches the end of the heap. A full heap of the
// default size holds 256 blocks of the smallest kind.
// Reset: reset is synchronous and active high. After it the block writes the
// initial free header in its init state (busy is high) and then goes idle.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator #(
   parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffha_pkg::req_type req_item,
   output logic              rsp_valid,
   output ffha_pkg::rsp_type rsp_item
);

   // Commands from the controller and compare results back from the
   // datapath are the only signals between the two halves.
   ffha_pkg::cmd_type cmd;
   ffha_pkg::sts_type sts;

   // The controller owns the sequencing and the handshake.
   ffha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the header store and the result registers; the
   // response word is read straight from those registers.
   ffha_dpath #(
      .HEAP_BYTES (HEAP_BYTES)
   ) u_dpath (
      .clock   (clock),
      .req_in  (req_item),
      .cmd     (cmd),
      .sts     (sts),
      .rsp_out (rsp_item)
   );

endmodule

[rtl/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker: port-level checks of the allocator
// Watches the handshake and the response word over time, bound to the top
// level.
// ----------------------------------------------------------------------------
module ffha_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input ffha_pkg::rsp_type rsp_item
);

   // An accepted request keeps the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // The strobe lasts exactly one cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held longer than one cycle");

   // A response is shown while busy and the block is free right after.
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy ##1 !busy)
      else $error("busy not in step with the response strobe");

   // A failed request carries no offset and no leak figures.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ffha_pkg::STATUS_OK)) |->
         ((rsp_item.payload_offset == 12'd0) && (rsp_item.leaked_objects == 9'd0) &&
          (rsp_item.leaked_bytes == 12'd0)))
      else $error("failed request returned nonzero fields");

   // A word is never accepted while a response is on the ports.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(start && !busy))
      else $error("request accepted during a response");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

[dv/tb_first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator: self-checking bench for the heap allocator
// Sends allocate, free, leak report and unused-code request words through the
// start/busy handshake in random bursts, predicts every response word with a
// shadow copy of the header chain and compares each rsp_valid strobe with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator;

   localparam int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEFAULT;
   localparam int SLOTS      = HEAP_BYTES / ffha_pkg::HDR_BYTES;
   localparam logic [1:0] FUNC_NONE = 2'd3;   // unused function code, must be a no-op

   // The scoreboard keeps its own header chain, one entry per 8-byte slot,
   // and a queue of response words that are still owed by the block.
   class heap_scoreboard;
      int unsigned       blk_len [SLOTS];
      bit                header_used [SLOTS];
      ffha_pkg::rsp_type owed_rsp [$];
      int                mismatches;

      function new();
         foreach (blk_len[i]) begin
            blk_len[i]     = 0;
            header_used[i] = 1'b0;
         end
         blk_len[0] = HEAP_BYTES - ffha_pkg::HDR_BYTES;
         mismatches = 0;
      endfunction

      function int pending();
         return owed_rsp.size();
      endfunction

      // Applies one accepted request word to the shadow heap and queues the
      // response word that the block must give for it.
      function ffha_pkg::rsp_type note_request(ffha_pkg::req_type w);
         ffha_pkg::rsp_type r;
         int unsigned       pos, sz, want, nxt, off;
         r   = '0;
         pos = 0;
         off = w.free_offset;
         case (w.func)
            ffha_pkg::FUNC_ALLOC: begin
               if (w.req_size == 0) begin
                  r.status = ffha_pkg::STATUS_ZERO;
               end else begin
                  want     = ((w.req_size + 7) / 8) * 8;
                  r.status = ffha_pkg::STATUS_NOMEM;
                  while (pos < HEAP_BYTES) begin
                     sz = blk_len[pos / 8];
                     if (!header_used[pos / 8] && sz >= want) begin
                        // Split only when the rest can hold a header and
                        // at least one 8-byte payload.
                        if (sz >= want + ffha_pkg::HDR_BYTES + 8) begin
                           blk_len[(pos + ffha_pkg::HDR_BYTES + want) / 8] =
                              sz - want - ffha_pkg::HDR_BYTES;
                           header_used[(pos + ffha_pkg::HDR_BYTES + want) / 8] = 1'b0;
                           blk_len[pos / 8] = want;
                        end
                        header_used[pos / 8] = 1'b1;
                        r.payload_offset = 12'(pos + ffha_pkg::HDR_BYTES);
                        r.status = ffha_pkg::STATUS_OK;
                        break;
                     end
                     pos += ffha_pkg::HDR_BYTES + sz;
                  end
               end
            end
            ffha_pkg::FUNC_FREE: begin
               r.status = ffha_pkg::STATUS_BAD_PTR;
               if (!w.ptr_is_null && off >= ffha_pkg::HDR_BYTES && off < HEAP_BYTES) begin
                  while (pos < HEAP_BYTES) begin
                     sz = blk_len[pos / 8];
                     if (pos + ffha_pkg::HDR_BYTES == off) begin
                        if (header_used[pos / 8]) begin
                           // Absorb every free block that directly follows.
                           header_used[pos / 8] = 1'b0;
                           nxt = pos + ffha_pkg::HDR_BYTES + sz;
                           while (nxt < HEAP_BYTES && !header_used[nxt / 8]) begin
                              sz  = sz + ffha_pkg::HDR_BYTES + blk_len[nxt / 8];
                              nxt = pos + ffha_pkg::HDR_BYTES + sz;
                           end
                           blk_len[pos / 8] = sz;
                           r.status = ffha_pkg::STATUS_OK;
                        end
                        break;
                     end
                     pos += ffha_pkg::HDR_BYTES + sz;
                  end
               end
            end
            ffha_pkg::FUNC_LEAK: begin
               while (pos < HEAP_BYTES) begin
                  sz = blk_len[pos / 8];
                  if (header_used[pos / 8]) begin
                     r.leaked_objects = r.leaked_objects + 9'd1;
                     r.leaked_bytes   = r.leaked_bytes + 12'(sz);
                  end
                  pos += ffha_pkg::HDR_BYTES + sz;
               end
            end
            default: ;
         endcase
         owed_rsp.push_back(r);
         return r;
      endfunction

      task report(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_response(ffha_pkg::rsp_type got);
         ffha_pkg::rsp_type exp;
         if (owed_rsp.size() == 0) begin
            report($sformatf("response word with none owed: %p", got));
            return;
         end
         exp = owed_rsp.pop_front();
         if (got.status !== exp.status)
            report($sformatf("status %0d, want %0d", got.status, exp.status));
         if (got.payload_offset !== exp.payload_offset)
            report($sformatf("payload_offset %0d, want %0d",
                             got.payload_offset, exp.payload_offset));
         if (got.leaked_objects !== exp.leaked_objects)
            report($sformatf("leaked_objects %0d, want %0d",
                             got.leaked_objects, exp.leaked_objects));
         if (got.leaked_bytes !== exp.leaked_bytes)
            report($sformatf("leaked_bytes %0d, want %0d",
                             got.leaked_bytes, exp.leaked_bytes));
      endtask
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   ffha_pkg::req_type req_item = '0;
   logic              rsp_valid;
   ffha_pkg::rsp_type rsp_item;

   heap_scoreboard sb = new();

   // Payload offsets that are allocated right now, and a short history of
   // offsets that were freed, used to aim double frees.
   int unsigned live_q [$];
   int unsigned freed_q [$];
   int          burst_left = 0;

   first_fit_heap_allocator #(
      .HEAP_BYTES(HEAP_BYTES)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always #10 clock = ~clock;

   // The receiver cannot hold the block off, so every strobe is a word.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_response(rsp_item);
      end
   end

   function automatic ffha_pkg::req_type make_word(logic [1:0] f, int unsigned sz, bit nul,
                                                   int unsigned off);
      ffha_pkg::req_type w;
      w.func        = f;
      w.req_size    = sz[12:0];
      w.ptr_is_null = nul;
      w.free_offset = off[12:0];
      return w;
   endfunction

   // Inserts a random gap between bursts; now and then a long burst runs
   // with no gap at all, so words also arrive back to back.
   task pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // Presents one request word and holds it until the block takes it. The
   // prediction is made at the accepting edge, and the lists of live and
   // freed offsets follow the predicted outcome.
   task send_word(ffha_pkg::req_type w);
      ffha_pkg::rsp_type exp;
      pace();
      @(negedge clock);
      req_item <= w;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      exp = sb.note_request(w);
      if (w.func == ffha_pkg::FUNC_ALLOC && exp.status == ffha_pkg::STATUS_OK)
         live_q.push_back(exp.payload_offset);
      if (w.func == ffha_pkg::FUNC_FREE && exp.status == ffha_pkg::STATUS_OK) begin
         foreach (live_q[i]) begin
            if (live_q[i] == w.free_offset) begin
               live_q.delete(i);
               break;
            end
         end
         freed_q.push_back(w.free_offset);
         if (freed_q.size() > 16) void'(freed_q.pop_front());
      end
   endtask

   // One random word of the general traffic mix. Most words are legal
   // allocates and frees of live blocks; the rest are rejected frees, leak
   // queries and the unused function code. Fields that the function does
   // not use carry random noise.
   task send_mixed(int unsigned alloc_max);
      int unsigned pick, sz, off, idx;
      bit          nul;
      pick = $urandom_range(0, 99);
      nul  = 1'($urandom_range(0, 1));
      off  = $urandom_range(0, 8191);
      if (pick < 40 || (pick < 70 && live_q.size() == 0)) begin
         case ($urandom_range(0, 19))
            0:       sz = $urandom_range(0, 8191);
            1:       sz = 0;
            2:       sz = $urandom_range(1, HEAP_BYTES);
            default: sz = $urandom_range(1, alloc_max);
         endcase
         send_word(make_word(ffha_pkg::FUNC_ALLOC, sz, nul, off));
      end else if (pick < 70) begin
         idx = $urandom_range(0, live_q.size() - 1);
         send_word(make_word(ffha_pkg::FUNC_FREE, $urandom_range(0, 8191), 1'b0,
                             live_q[idx]));
      end else if (pick < 80) begin
         // Frees meant to be rejected: null pointer, stray offset, offset inside a
         // payload, and a second free of a block already freed.
         case ($urandom_range(0, 3))
            0: begin
               if (live_q.size() > 0) off = live_q[$urandom_range(0, live_q.size() - 1)];
               nul = 1'b1;
            end
            1: nul = 1'b0;
            2: begin
               if (live_q.size() > 0)
                  off = live_q[$urandom_range(0, live_q.size() - 1)] + $urandom_range(1, 7);
               nul = 1'b0;
            end
            default: begin
               if (freed_q.size() > 0) off = freed_q[$urandom_range(0, freed_q.size() - 1)];
               nul = 1'b0;
            end
         endcase
         send_word(make_word(ffha_pkg::FUNC_FREE, $urandom_range(0, 8191), nul, off));
      end else if (pick < 95) begin
         send_word(make_word(ffha_pkg::FUNC_LEAK, $urandom_range(0, 8191), nul, off));
      end else begin
         send_word(make_word(FUNC_NONE, $urandom_range(0, 8191), nul, off));
      end
   endtask

   initial begin
      int unsigned       top, idx;
      ffha_pkg::rsp_type last;

      // Synchronous reset first, then the block writes its initial free header on
      // its own and keeps busy high until it is ready.
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words on the empty heap: zero size, oversize requests,
      // every way a free can be rejected, the unused function code, an
      // allocate that takes the whole heap, one that leaves too little to
      // split, one that splits off the smallest possible block, and a free
      // that merges forward across several blocks.
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 0, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 8191, 1'b1, 8191));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, HEAP_BYTES - 7, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_LEAK, 0, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b1, 8));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 8));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, HEAP_BYTES));
      send_word(make_word(FUNC_NONE, 8191, 1'b1, 8191));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, HEAP_BYTES - 8, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_LEAK, 0, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 1, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 8));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, HEAP_BYTES - 16, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 8));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, HEAP_BYTES - 24, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 1, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_LEAK, 0, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, HEAP_BYTES - 8));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 8));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 1, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 100, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_ALLOC, 13, 1'b0, 0));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 28));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 8191));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 24));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 136));
      send_word(make_word(ffha_pkg::FUNC_FREE, 0, 1'b0, 8));

      // Fill the merged heap with the smallest blocks until it runs out,
      // which gives the longest walks and the largest leak counts.
      do begin
         send_word(make_word(ffha_pkg::FUNC_ALLOC, $urandom_range(1, 8),
                             1'($urandom_range(0, 1)), $urandom_range(0, 8191)));
         last = sb.owed_rsp[sb.owed_rsp.size() - 1];
      end while (last.status == ffha_pkg::STATUS_OK);
      send_word(make_word(ffha_pkg::FUNC_LEAK, 0, 1'b0, 0));

      // Let the block drain completely once before the mixed traffic.
      @(negedge clock);
      start <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);

      repeat (150) send_mixed(64);

      // Freeing from the top address down lets each free absorb the merged
      // space above it, so the heap coalesces again.
      while (live_q.size() > 0) begin
         top = 0;
         idx = 0;
         foreach (live_q[i]) begin
            if (live_q[i] > top) begin
               top = live_q[i];
               idx = i;
            end
         end
         send_word(make_word(ffha_pkg::FUNC_FREE, $urandom_range(0, 8191), 1'b0,
                             live_q[idx]));
         if ($urandom_range(0, 15) == 0)
            send_word(make_word(ffha_pkg::FUNC_LEAK, 0, 1'b0, 0));
      end
      send_word(make_word(ffha_pkg::FUNC_LEAK, 0, 1'b0, 0));

      repeat (150) send_mixed(512);

      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      // Anything that shows up in this window is a word nobody asked for.
      repeat (600) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // This timeout catches a block that stops handshaking.
   initial begin
      #50_000_000;
      $display("[%0t] TIMEOUT: %0d response words still owed", $realtime, sb.pending());
      $display("== FAIL ==");
      $finish;
   end

endmodule
